// ===== src/wrcm_pkg.sv =====
// Shared widths, constants and types for the windowed RMS current meter.
// Used by every module of the block; depends on nothing else.
package wrcm_pkg;

  // Converter and window sizing
  localparam int ADC_BITS        = 10;
  localparam int RMS_WINDOW_LOG2 = 8;
  localparam int CAL_WINDOW_LOG2 = 8;

  // Fixed field widths of the stream payloads
  localparam int ADC_IN_W  = 10;
  localparam int GAIN_W    = 16;
  localparam int INST_W    = 19;
  localparam int RMS_W     = 18;
  localparam int OFFSET_W  = 10;

  localparam int IN_DATA_W     = ((ADC_IN_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = INST_W + RMS_W + OFFSET_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Internal datapath widths
  localparam int MS_W     = 2 * ADC_BITS;              // mean square
  localparam int SQ_W     = MS_W + RMS_WINDOW_LOG2;    // window sum of squares
  localparam int RAW_W    = ADC_BITS + CAL_WINDOW_LOG2; // window sum of raw samples
  localparam int OPA_W    = ADC_BITS + 1;              // signed multiplier operand A
  localparam int OPB_W    = GAIN_W + 1;                // signed multiplier operand B
  localparam int PROD_W   = OPA_W + OPB_W;
  localparam int REM_W    = ADC_BITS + 3;              // square root remainder
  localparam int ITER_W   = $clog2(ADC_BITS + 1);

  localparam int Q8_HALF  = 128;
  localparam int Q8_SHIFT = 8;
  localparam int RMS_MAX  = (1 << RMS_W) - 1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(18944);
  localparam logic [ADC_BITS-1:0] OFFSET_RESET = ADC_BITS'(512);

  // Request kinds carried in the input tuser
  localparam logic REQ_SAMPLE    = 1'b0;
  localparam logic REQ_CALIBRATE = 1'b1;

  // Control from the sequencer to the square root unit
  typedef struct packed {
    logic            start;
    logic [MS_W-1:0] radicand;
  } sqrt_ctl_t;

endpackage

// ===== src/wrcm_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on wrcm_pkg for the operand widths.
module wrcm_mul (
  input  logic                                clk_i,
  input  logic signed [wrcm_pkg::OPA_W-1:0]   a_i,
  input  logic signed [wrcm_pkg::OPB_W-1:0]   b_i,
  output logic signed [wrcm_pkg::PROD_W-1:0]  p_o
);
  import wrcm_pkg::*;

  logic signed [PROD_W-1:0] p_d;
  logic signed [PROD_W-1:0] p_q;

  assign p_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== src/wrcm_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on wrcm_pkg for widths and the control struct.
module wrcm_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wrcm_pkg::sqrt_ctl_t           ctl_i,
  output logic                          busy_o,
  output logic [wrcm_pkg::ADC_BITS-1:0] root_o
);
  import wrcm_pkg::*;

  logic                busy_q;
  logic [ITER_W-1:0]   cnt_q;
  logic [MS_W-1:0]     val_q;
  logic [REM_W-1:0]    rem_q;
  logic [ADC_BITS-1:0] root_q;

  logic [REM_W-1:0]    rem_shift;
  logic [REM_W-1:0]    trial;
  logic                take;

  // Bring in the next two radicand bits and try the candidate 4*root + 1.
  assign rem_shift = {rem_q[REM_W-3:0], val_q[MS_W-1 -: 2]};
  assign trial     = REM_W'({root_q, 2'b01});
  assign take      = (rem_shift >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      val_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= ITER_W'(ADC_BITS);
      val_q  <= ctl_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[MS_W-3:0], 2'b00};
      if (take) begin
        rem_q  <= rem_shift - trial;
        root_q <= {root_q[ADC_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift;
        root_q <= {root_q[ADC_BITS-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== src/windowed_rms_current_meter.sv =====
// Windowed RMS current meter: top level with the item sequencer and state.
// Depends on wrcm_pkg, wrcm_mul and wrcm_isqrt.
//
// Each input transfer is either a converter sample or a calibrate request and
// produces exactly one output transfer. A sample steps through S_INST, S_SQ,
// S_ACC, S_RMS and S_OUT; a sample that closes an RMS window also steps
// through S_ROOT_GO and S_ROOT, where it waits while the square root unit
// produces one root bit per cycle; a calibrate request steps through
// S_RMS and S_OUT. All multiplications go through one shared multiplier in
// turn. While an item is in work s_axis_tready is low; a finished
// result waits in the output register, so a slow consumer only stalls the
// block when a second result is ready. The gain register may be written at any
// time the block is idle and is always ready.
module windowed_rms_current_meter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [wrcm_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [9:0] adc_sample
  input  logic                                 s_axis_tuser,  // [0] req_type
  // Output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [18:0] instant_ma, [36:19] rms_ma, [46:37] offset_counts
  output logic [wrcm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tuser,  // [0] window_done
  // Gain register write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wrcm_pkg::GAIN_W-1:0]          cfg_data_i
);
  import wrcm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INST,
    S_SQ,
    S_ACC,
    S_ROOT_GO,
    S_ROOT,
    S_RMS,
    S_OUT
  } state_e;

  localparam int SH_W = PROD_W - Q8_SHIFT;

  state_e                      state_q;
  logic [GAIN_W-1:0]           gain_q;
  logic [ADC_BITS-1:0]         sample_q;
  logic [ADC_BITS-1:0]         zero_offset_q;
  logic [RMS_WINDOW_LOG2-1:0]  rms_cnt_q;
  logic [SQ_W-1:0]             square_sum_q;
  logic [MS_W-1:0]             mean_square_q;
  logic [CAL_WINDOW_LOG2-1:0]  cal_cnt_q;
  logic [RAW_W-1:0]            raw_sum_q;
  logic [ADC_BITS-1:0]         raw_avg_q;
  logic [INST_W-1:0]           instant_q;
  logic                        done_q;
  logic                        m_valid_q;
  logic [OUT_DATA_W-1:0]       m_data_q;
  logic                        m_user_q;

  logic [ADC_BITS-1:0]         sample_in;
  logic signed [OPA_W-1:0]     diff;
  logic [OPA_W-1:0]            neg_diff;
  logic [ADC_BITS-1:0]         mag;
  logic signed [OPA_W-1:0]     mul_a;
  logic signed [OPB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]    product;

  logic signed [PROD_W:0]      inst_rnd;
  logic [SH_W:0]               inst_sh;
  logic [SH_W-INST_W+1:0]      inst_top;
  logic [INST_W-1:0]           inst_sat;
  logic [PROD_W-1:0]           rms_rnd;
  logic [SH_W-1:0]             rms_sh;
  logic [RMS_W-1:0]            rms_sat;

  logic [SQ_W-1:0]             sum_next;
  logic [RAW_W-1:0]            raw_next;
  logic                        out_free;

  sqrt_ctl_t                   sqrt_ctl;
  logic                        sqrt_busy;
  logic [ADC_BITS-1:0]         root;

  assign sample_in = ADC_BITS'(s_axis_tdata[ADC_IN_W-1:0]);
  assign diff      = $signed({1'b0, sample_q}) - $signed({1'b0, zero_offset_q});
  assign neg_diff  = -diff;
  assign mag       = diff[ADC_BITS] ? neg_diff[ADC_BITS-1:0] : diff[ADC_BITS-1:0];

  // Operand selection for the shared multiplier; the default keeps root * gain
  // so the product stays put while a result waits for the output register.
  always_comb begin
    unique case (state_q)
      S_INST: begin
        mul_a = diff;
        mul_b = $signed(OPB_W'(gain_q));
      end
      S_SQ: begin
        mul_a = $signed(OPA_W'(mag));
        mul_b = $signed(OPB_W'(mag));
      end
      default: begin
        mul_a = $signed(OPA_W'(root));
        mul_b = $signed(OPB_W'(gain_q));
      end
    endcase
  end

  wrcm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (product)
  );

  assign sqrt_ctl.start    = (state_q == S_ROOT_GO);
  assign sqrt_ctl.radicand = mean_square_q;

  wrcm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sqrt_ctl),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  // Instant current: round half up by adding half an LSB and flooring.
  assign inst_rnd = $signed({product[PROD_W-1], product}) + $signed((PROD_W+1)'(Q8_HALF));
  assign inst_sh  = inst_rnd[PROD_W:Q8_SHIFT];
  assign inst_top = inst_sh[SH_W:INST_W-1];
  always_comb begin
    if ((&inst_top) || !(|inst_top)) begin
      inst_sat = inst_sh[INST_W-1:0];
    end else if (inst_sh[SH_W]) begin
      inst_sat = {1'b1, {(INST_W-1){1'b0}}};
    end else begin
      inst_sat = {1'b0, {(INST_W-1){1'b1}}};
    end
  end

  // RMS current: the product is never negative here.
  assign rms_rnd = $unsigned(product) + PROD_W'(Q8_HALF);
  assign rms_sh  = rms_rnd[PROD_W-1:Q8_SHIFT];
  assign rms_sat = (rms_sh > SH_W'(RMS_MAX)) ? RMS_W'(RMS_MAX) : RMS_W'(rms_sh);

  assign sum_next = square_sum_q + SQ_W'(product[MS_W-1:0]);
  assign raw_next = raw_sum_q + RAW_W'(sample_q);
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      gain_q        <= GAIN_RESET;
      sample_q      <= '0;
      zero_offset_q <= OFFSET_RESET;
      rms_cnt_q     <= '0;
      square_sum_q  <= '0;
      mean_square_q <= '0;
      cal_cnt_q     <= '0;
      raw_sum_q     <= '0;
      raw_avg_q     <= '0;
      instant_q     <= '0;
      done_q        <= 1'b0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      m_user_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
      if ((state_q == S_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sample_q  <= sample_in;
            instant_q <= '0;
            done_q    <= 1'b0;
            if (s_axis_tuser == REQ_CALIBRATE) begin
              zero_offset_q <= raw_avg_q;
              state_q       <= S_RMS;
            end else begin
              state_q <= S_INST;
            end
          end
        end
        S_INST: begin
          state_q <= S_SQ;
        end
        S_SQ: begin
          instant_q <= inst_sat;
          state_q   <= S_ACC;
        end
        S_ACC: begin
          rms_cnt_q <= rms_cnt_q + 1'b1;
          cal_cnt_q <= cal_cnt_q + 1'b1;
          if (&cal_cnt_q) begin
            raw_avg_q <= raw_next[RAW_W-1:CAL_WINDOW_LOG2];
            raw_sum_q <= '0;
          end else begin
            raw_sum_q <= raw_next;
          end
          if (&rms_cnt_q) begin
            mean_square_q <= sum_next[SQ_W-1:RMS_WINDOW_LOG2];
            square_sum_q  <= '0;
            done_q        <= 1'b1;
            state_q       <= S_ROOT_GO;
          end else begin
            square_sum_q <= sum_next;
            state_q      <= S_RMS;
          end
        end
        S_ROOT_GO: begin
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (!sqrt_busy) begin
            state_q <= S_RMS;
          end
        end
        S_RMS: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_data_q  <= OUT_DATA_W'({OFFSET_W'(zero_offset_q), rms_sat, instant_q});
            m_user_q  <= done_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ===== src/wrcm_checker.sv =====
// Port-level checks for the windowed RMS current meter, bound to the top level.
// Depends on wrcm_pkg for the stream widths.
module wrcm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [wrcm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [wrcm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [wrcm_pkg::GAIN_W-1:0]     cfg_data_i
);
  import wrcm_pkg::*;

  logic in_xfer;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result is held unchanged until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // The block works on one item at a time.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input accepted while an item was in work");

  // No result can appear in the cycle straight after an input transfer.
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // The gain register never refuses a write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind windowed_rms_current_meter wrcm_checker u_wrcm_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the windowed RMS current meter.
// Drives sample and calibrate transfers, predicts every reading and compares them.
// Depends on wrcm_pkg and windowed_rms_current_meter.
`timescale 1ns / 100ps

module testbench;
  import wrcm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 170;
  localparam int RMS_SAT       = (1 << RMS_W) - 1;
  localparam int INST_HI       = (1 << (INST_W - 1)) - 1;
  localparam int INST_LO       = -(1 << (INST_W - 1));

  typedef struct {
    logic signed [INST_W-1:0] instant;
    logic [RMS_W-1:0]         rms;
    logic                     done;
    logic [OFFSET_W-1:0]      offset;
  } reading_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [GAIN_W-1:0]     cfg_data_i;

  // Predicted meter state
  logic [GAIN_W-1:0]   gain_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [ADC_BITS-1:0] raw_avg_q;
  int                  rms_count;
  int                  cal_count;
  longint              square_sum;
  longint              mean_square;
  longint              raw_sum;

  reading_t expected_readings[$];

  int  cycle_count;
  int  error_count;
  int  items_sent;
  int  calibrations_sent;
  int  windows_closed;
  int  gain_writes;
  int  readings_checked;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  hold_ready;

  windowed_rms_current_meter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d readings still awaited.", cycle_count,
                 expected_readings.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic longint floor_sqrt(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void clear_meter_state();
    gain_q      = GAIN_RESET;
    offset_q    = OFFSET_RESET;
    raw_avg_q   = '0;
    rms_count   = 0;
    cal_count   = 0;
    square_sum  = 0;
    mean_square = 0;
    raw_sum     = 0;
  endfunction

  // Advances the predicted state by one accepted item and returns its reading.
  function automatic reading_t predict_reading(logic req, logic [ADC_IN_W-1:0] adc);
    reading_t r;
    longint   diff;
    longint   inst;
    longint   rms_l;
    r.done = 1'b0;
    inst   = 0;
    if (req == REQ_CALIBRATE) begin
      offset_q = raw_avg_q;
    end else begin
      diff = longint'(adc) - longint'(offset_q);
      // Adding half and flooring rounds ties towards plus infinity.
      inst = (diff * longint'(gain_q) + Q8_HALF) >>> Q8_SHIFT;
      if (inst > INST_HI) inst = INST_HI;
      if (inst < INST_LO) inst = INST_LO;
      square_sum += diff * diff;
      rms_count++;
      if (rms_count == (1 << RMS_WINDOW_LOG2)) begin
        mean_square = square_sum >> RMS_WINDOW_LOG2;
        square_sum  = 0;
        rms_count   = 0;
        r.done      = 1'b1;
        windows_closed++;
      end
      raw_sum += longint'(adc);
      cal_count++;
      if (cal_count == (1 << CAL_WINDOW_LOG2)) begin
        raw_avg_q = ADC_BITS'(raw_sum >> CAL_WINDOW_LOG2);
        raw_sum   = 0;
        cal_count = 0;
      end
    end
    rms_l = (floor_sqrt(mean_square) * longint'(gain_q) + Q8_HALF) >> Q8_SHIFT;
    if (rms_l > RMS_SAT) rms_l = RMS_SAT;
    r.instant = inst[INST_W-1:0];
    r.rms     = rms_l[RMS_W-1:0];
    r.offset  = offset_q;
    return r;
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic void check_reading(logic [OUT_DATA_W-1:0] data, logic user);
    reading_t want;
    reading_t got;
    got.instant = data[INST_W-1:0];
    got.rms     = data[INST_W+RMS_W-1:INST_W];
    got.offset  = data[INST_W+RMS_W+OFFSET_W-1:INST_W+RMS_W];
    got.done    = user;
    if (expected_readings.size() == 0) begin
      report_error($sformatf("reading with none awaited: instant %0d rms %0d",
                             got.instant, got.rms));
      return;
    end
    want = expected_readings.pop_front();
    readings_checked++;
    if (got.instant !== want.instant || got.rms !== want.rms ||
        got.done !== want.done || got.offset !== want.offset)
      report_error($sformatf(
        "reading %0d: expected inst %0d rms %0d done %0b off %0d, got %0d %0d %0b %0d",
        readings_checked, want.instant, want.rms, want.done, want.offset,
        got.instant, got.rms, got.done, got.offset));
  endfunction

  // Consumer side: random stalls per transfer, plus a long hold when asked.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clk_i);
      if (gap > 0 || hold_ready) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
        while (hold_ready) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_reading(m_axis_tdata, m_axis_tuser);
    end
  end

  // Offers one item and waits for its transfer; valid stays high afterwards.
  task automatic send_item(logic req, logic [ADC_IN_W-1:0] adc);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(adc);
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_readings.push_back(predict_reading(req, adc));
    items_sent++;
    if (req == REQ_CALIBRATE) calibrations_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_gain(logic [GAIN_W-1:0] g);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_q = g;
    gain_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ADC_IN_W-1:0] clamp_adc(int v);
    if (v < 0) return '0;
    if (v > (1 << ADC_BITS) - 1) return '1;
    return ADC_IN_W'(v);
  endfunction

  task automatic test_reset_readings();
    // Reset gain, midscale offset, no window closed yet: rms must read zero.
    send_item(REQ_SAMPLE, 10'd512);
    send_item(REQ_SAMPLE, 10'd1023);
    send_item(REQ_SAMPLE, 10'd0);
    send_item(REQ_SAMPLE, 10'd513);
    send_item(REQ_SAMPLE, 10'd511);
  endtask

  task automatic test_rounding_ties();
    // A gain of 1.5 counts puts plus and minus halves on the rounding boundary.
    set_gain(16'd384);
    send_item(REQ_SAMPLE, 10'd513);
    send_item(REQ_SAMPLE, 10'd511);
    send_item(REQ_SAMPLE, 10'd515);
    send_item(REQ_SAMPLE, 10'd509);
    set_gain(16'd128);
    send_item(REQ_SAMPLE, 10'd513);
    send_item(REQ_SAMPLE, 10'd511);
  endtask

  task automatic test_early_calibrate();
    // No calibration window has closed, so the offset drops to zero and the
    // sample value carried with the request is ignored.
    set_gain(GAIN_RESET);
    send_item(REQ_CALIBRATE, 10'd1023);
    send_item(REQ_SAMPLE, 10'd0);
    send_item(REQ_SAMPLE, 10'd1023);
  endtask

  task automatic test_gain_extremes();
    set_gain(16'd0);
    send_item(REQ_SAMPLE, 10'd1023);
    send_item(REQ_SAMPLE, 10'd0);
    set_gain(16'hFFFF);
    send_item(REQ_SAMPLE, 10'd1023);
    send_item(REQ_SAMPLE, 10'd0);
    send_item(REQ_CALIBRATE, 10'h2AA);
  endtask

  task automatic test_random_windows();
    logic [GAIN_W-1:0] gains [6];
    int                bias;
    int                swing;
    int                pick;
    gains[0] = GAIN_RESET;
    gains[1] = GAIN_W'($urandom);
    gains[2] = 16'hFFFF;
    gains[3] = 16'd1;
    gains[4] = GAIN_W'($urandom_range(256, 8192));
    gains[5] = GAIN_W'($urandom);
    for (int p = 0; p < 6; p++) begin
      set_gain(gains[p]);
      tx_idle_on = (p % 3 != 0);
      rx_idle_on = (p % 3 != 1);
      bias  = $urandom_range(380, 640);
      swing = $urandom_range(20, 400);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // The producer goes quiet until every reading has come back.
        if (p == 2 && i == PHASE_ITEMS / 2) wait_idle();
        pick = $urandom_range(0, 99);
        if (pick < 3)
          send_item(REQ_CALIBRATE, ADC_IN_W'($urandom));
        else if (pick < 8)
          send_item(REQ_SAMPLE, pick[0] ? 10'd1023 : 10'd0);
        else if (pick < 35)
          send_item(REQ_SAMPLE, ADC_IN_W'($urandom));
        else
          send_item(REQ_SAMPLE, clamp_adc(bias + $urandom_range(0, 2 * swing) - swing));
      end
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    fork
      begin
        hold_ready = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_ready = 1'b0;
      end
      for (int i = 0; i < 24; i++)
        send_item(REQ_SAMPLE, ADC_IN_W'($urandom));
    join
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 8; i++)
      send_item((i == 5) ? REQ_CALIBRATE : REQ_SAMPLE, ADC_IN_W'($urandom));
  endtask

  initial begin
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    s_axis_tuser      = REQ_SAMPLE;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    rst_ni            = 1'b0;
    error_count       = 0;
    items_sent        = 0;
    calibrations_sent = 0;
    windows_closed    = 0;
    gain_writes       = 0;
    readings_checked  = 0;
    tx_idle_on        = 1'b1;
    rx_idle_on        = 1'b1;
    hold_ready        = 1'b0;
    clear_meter_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_readings();
    test_rounding_ties();
    test_early_calibrate();
    test_gain_extremes();
    test_random_windows();
    test_output_backpressure();
    wait_idle();

    $display("Covered %0d items (%0d calibrate requests), %0d RMS windows closed,",
             items_sent, calibrations_sent, windows_closed);
    $display("%0d gain writes, %0d readings checked, %0d errors.",
             gain_writes, readings_checked, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
